[rtl/phq_pkg.sv]
// Package: shared types, constants and codes of the presence hysteresis qualifier.
package phq_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int DEV_W       = $clog2(MAX_DEVICES);
  localparam int CNT_W       = 4;
  localparam int RUN_W       = 8;
  localparam int TIME_W      = 32;
  localparam int ATT_W       = 16;
  localparam int USED_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 24;

  localparam logic [RUN_W-1:0]  RUN_MAX = {RUN_W{1'b1}};
  localparam logic [ATT_W-1:0]  ATT_MAX = {ATT_W{1'b1}};
  localparam logic [TIME_W-1:0] T_UNSET = '0;
  localparam logic [RUN_W-1:0]  CONFIRM_ONE = RUN_W'(1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_CONFIRM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_STABLE_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_CONFIRM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_STABLE_MS = 3'd4;

  // Action codes
  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_FAIL  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  device_count;
    logic [RUN_W-1:0]  hit_confirm;
    logic [TIME_W-1:0] hit_stable_ms;
    logic [RUN_W-1:0]  miss_confirm;
    logic [TIME_W-1:0] miss_stable_ms;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [DEV_W-1:0]  device;
    logic              probe_ok;
    logic              configured;
    logic [USED_W-1:0] probe_tries;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic              present;
    logic [RUN_W-1:0]  hit_run;
    logic [RUN_W-1:0]  miss_run;
    logic [TIME_W-1:0] hit_start;
    logic [TIME_W-1:0] miss_start;
    logic [ATT_W-1:0]  attempts;
  } entry_t;

  typedef struct packed {
    logic             device_present;
    logic             changed;
    logic             fast_rescan;
    logic [ATT_W-1:0] recover_attempts;
    logic             ignored;
  } result_t;

  localparam entry_t ENTRY_RESET = '0;

endpackage

[rtl/presence_hysteresis_qualifier.sv]
// Top level: debounced per-device presence tracker with stream ports and config port.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: action; tdata: device..now_ms
//  out_    | out | out_tvalid/out_tready| tdata: present, changed, fast, attempts, ign.
//  cfg_    | in  | cfg_we (no ready)    | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_tready is high; items pass the
// input register, then the result register. The per-device entry is read, updated
// and written back in the cycle the item leaves the input register, so back-to-back
// items on the same device see each other's updates. A stall on out_tready holds
// the full registers; in_tready drops only when both are full. Synchronous
// active-low reset clears all device entries and loads the configuration defaults.
module presence_hysteresis_qualifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, low bit up: device[2:0], probe_ok[3], configured[4],
  // probe_tries[12:5], now_ms[44:13], zero fill[47:45]
  input  logic [phq_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: action (0 probe result, 1 runtime failure)
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, low bit up: device_present[0], changed[1], fast_rescan[2],
  // recover_attempts[18:3], ignored[19], zero fill[23:20]
  output logic [phq_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [phq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [phq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  phq_pkg::cfg_t    cfg_r;
  logic             s1_valid_r;
  phq_pkg::item_t   s1_item_r;
  logic             out_valid_r;
  phq_pkg::result_t out_res_r;

  phq_pkg::item_t   in_item;
  phq_pkg::entry_t  cur_entry;
  phq_pkg::entry_t  nxt_entry;
  phq_pkg::result_t core_res;
  logic             core_wr;
  logic             s2_ready;
  logic             s1_fire;
  logic             in_fire;

  // unpack the incoming transaction
  always_comb begin
    in_item.action        = in_tuser;
    in_item.device        = in_tdata[2:0];
    in_item.probe_ok      = in_tdata[3];
    in_item.configured    = in_tdata[4];
    in_item.probe_tries   = in_tdata[12:5];
    in_item.now_ms        = in_tdata[44:13];
  end

  // output register frees when empty or being taken
  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_count   <= phq_pkg::CNT_W'(8);
      cfg_r.hit_confirm    <= phq_pkg::RUN_W'(2);
      cfg_r.hit_stable_ms  <= '0;
      cfg_r.miss_confirm   <= phq_pkg::RUN_W'(2);
      cfg_r.miss_stable_ms <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phq_pkg::CFG_DEVICE_COUNT:   cfg_r.device_count   <= cfg_wdata[phq_pkg::CNT_W-1:0];
        phq_pkg::CFG_HIT_CONFIRM:    cfg_r.hit_confirm    <= cfg_wdata[phq_pkg::RUN_W-1:0];
        phq_pkg::CFG_HIT_STABLE_MS:  cfg_r.hit_stable_ms  <= cfg_wdata;
        phq_pkg::CFG_MISS_CONFIRM:   cfg_r.miss_confirm   <= cfg_wdata[phq_pkg::RUN_W-1:0];
        phq_pkg::CFG_MISS_STABLE_MS: cfg_r.miss_stable_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
  end

  phq_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (s1_item_r.device),
    .rd_entry (cur_entry),
    .wr_en    (s1_fire && core_wr),
    .wr_idx   (s1_item_r.device),
    .wr_entry (nxt_entry)
  );

  phq_core u_core (
    .cfg   (cfg_r),
    .item  (s1_item_r),
    .cur   (cur_entry),
    .nxt   (nxt_entry),
    .wr_en (core_wr),
    .res   (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) out_res_r <= core_res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.ignored, out_res_r.recover_attempts,
                       out_res_r.fast_rescan, out_res_r.changed,
                       out_res_r.device_present};

endmodule

[rtl/phq_state.sv]
// Per-device state registers with one read port and one write port.
module phq_state (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [phq_pkg::DEV_W-1:0]  rd_idx,
  output phq_pkg::entry_t            rd_entry,
  input  logic                       wr_en,
  input  logic [phq_pkg::DEV_W-1:0]  wr_idx,
  input  phq_pkg::entry_t            wr_entry
);

  phq_pkg::entry_t entries_r [phq_pkg::MAX_DEVICES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < phq_pkg::MAX_DEVICES; i++) begin
        entries_r[i] <= phq_pkg::ENTRY_RESET;
      end
    end else if (wr_en) begin
      entries_r[wr_idx] <= wr_entry;
    end
  end

  assign rd_entry = entries_r[rd_idx];

endmodule

[rtl/phq_core.sv]
// Combinational update of one device entry and the result of one transaction.
module phq_core (
  input  phq_pkg::cfg_t    cfg,
  input  phq_pkg::item_t   item,
  input  phq_pkg::entry_t  cur,
  output phq_pkg::entry_t  nxt,
  output logic             wr_en,
  output phq_pkg::result_t res
);

  logic [phq_pkg::CNT_W-1:0]  limit;
  logic                       ignored;
  logic                       apply;
  logic                       tgt;
  logic                       mok;
  logic                       go;
  logic                       changed;
  logic                       fast;
  logic [phq_pkg::ATT_W:0]    att_sum;
  phq_pkg::entry_t            e;

  always_comb begin
    limit = (cfg.device_count > phq_pkg::CNT_W'(phq_pkg::MAX_DEVICES))
          ? phq_pkg::CNT_W'(phq_pkg::MAX_DEVICES) : cfg.device_count;
    ignored = (phq_pkg::CNT_W'(item.device) >= limit);

    e       = cur;
    apply   = 1'b0;
    tgt     = 1'b0;
    mok     = 1'b1;
    go      = 1'b1;
    changed = 1'b0;
    fast    = 1'b0;
    att_sum = {1'b0, cur.attempts} + (phq_pkg::ATT_W + 1)'(item.probe_tries);

    if (!item.configured) begin
      apply = 1'b1;
    end else begin
      if (item.action == phq_pkg::ACT_PROBE) begin
        if (!e.present) begin
          e.attempts = att_sum[phq_pkg::ATT_W] ? phq_pkg::ATT_MAX
                                                : att_sum[phq_pkg::ATT_W-1:0];
        end else if (item.probe_ok) begin
          e.attempts = '0;
        end
      end

      if (item.action == phq_pkg::ACT_PROBE && item.probe_ok) begin
        // hit: drop the miss streak, run the hit debounce while absent
        e.miss_run   = '0;
        e.miss_start = phq_pkg::T_UNSET;
        if (!e.present && cfg.hit_confirm > phq_pkg::CONFIRM_ONE) begin
          if (e.hit_start == phq_pkg::T_UNSET) e.hit_start = item.now_ms;
          if (e.hit_run != phq_pkg::RUN_MAX) e.hit_run = e.hit_run + phq_pkg::RUN_W'(1);
          if (e.hit_run < cfg.hit_confirm ||
              (item.now_ms - e.hit_start) < cfg.hit_stable_ms) go = 1'b0;
        end
        apply = go;
        tgt   = 1'b1;
      end else begin
        // miss or runtime failure; a failed probe also drops the hit streak
        if (item.action == phq_pkg::ACT_PROBE) begin
          e.hit_run   = '0;
          e.hit_start = phq_pkg::T_UNSET;
        end
        if (e.present && cfg.miss_confirm > phq_pkg::CONFIRM_ONE) begin
          if (e.miss_start == phq_pkg::T_UNSET) e.miss_start = item.now_ms;
          if (e.miss_run != phq_pkg::RUN_MAX) e.miss_run = e.miss_run + phq_pkg::RUN_W'(1);
          if (e.miss_run < cfg.miss_confirm ||
              (item.now_ms - e.miss_start) < cfg.miss_stable_ms) mok = 1'b0;
        end
        apply = mok;
      end
    end

    if (apply && (e.present != tgt)) begin
      e.present    = tgt;
      changed      = 1'b1;
      e.hit_run    = '0;
      e.miss_run   = '0;
      e.hit_start  = phq_pkg::T_UNSET;
      e.miss_start = phq_pkg::T_UNSET;
      if (tgt) e.attempts = '0;
      else     fast = 1'b1;
    end

    nxt   = e;
    wr_en = !ignored;

    if (ignored) begin
      res         = '0;
      res.ignored = 1'b1;
    end else begin
      res.device_present   = e.present;
      res.changed          = changed;
      res.fast_rescan      = fast;
      res.recover_attempts = e.attempts;
      res.ignored          = 1'b0;
    end
  end

endmodule
